>>> src/lcsa_pkg.sv
// ----------------------------------------------------------------------------
// lcsa_pkg
// Shared types, constants and the CORDIC arctangent table for the lab-to-CM
// angle converter.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsa_pkg;

	// CORDIC datapath width: covers magnitude growth of a gamma-scaled vector
	localparam int CW         = 36;
	localparam int DIV_STEPS  = 30;
	localparam int SQRT_STEPS = 32;

	typedef logic signed [CW-1:0] cord_t;
	typedef logic [2:0]           cfg_idx_t;

	localparam logic [31:0] ONE_Q30      = 32'd1073741824;
	localparam logic [31:0] PI_Q30       = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

	localparam cfg_idx_t REG_GAMMA   = 3'd0;
	localparam cfg_idx_t REG_BETA    = 3'd1;
	localparam cfg_idx_t REG_HEAVY_E = 3'd2;
	localparam cfg_idx_t REG_LIGHT_E = 3'd3;
	localparam cfg_idx_t REG_MOM     = 3'd4;

	localparam logic [31:0] RST_GAMMA   = 32'd1073741824;
	localparam logic [31:0] RST_BETA    = 32'd0;
	localparam logic [31:0] RST_HEAVY_E = 32'd122920173;
	localparam logic [31:0] RST_LIGHT_E = 32'd61490594;
	localparam logic [31:0] RST_MOM     = 32'd0;

	// atan(2^-i) in Q30
	function automatic cord_t atan_step(input int unsigned i);
		cord_t r;
		case (i)
			0: r = 36'sd843314857;
			1: r = 36'sd497837829;
			2: r = 36'sd263043837;
			3: r = 36'sd133525159;
			4: r = 36'sd67021687;
			5: r = 36'sd33543516;
			6: r = 36'sd16775851;
			7: r = 36'sd8388437;
			8: r = 36'sd4194283;
			9: r = 36'sd2097149;
			default: r = (i <= 30) ? cord_t'(64'd1 << (30 - i)) : '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/lcsa_cordic_cell.sv
// ----------------------------------------------------------------------------
// lcsa_cordic_cell
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_cordic_cell
	import lcsa_pkg::*;
#(
	parameter int STEP   = 0,
	parameter bit VECTOR = 1'b0,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vld_in,
	input  wire cord_t             x_in,
	input  wire cord_t             y_in,
	input  wire cord_t             z_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   vld_out,
	output cord_t                  x_out,
	output cord_t                  y_out,
	output cord_t                  z_out,
	output logic [SIDE_W-1:0]      side_out
);

	cord_t dx, dy, ang;
	logic  dir;

	always_comb begin
		dx  = y_in >>> STEP;
		dy  = x_in >>> STEP;
		ang = atan_step(STEP);
		// vectoring drives y to zero, rotation drives z to zero
		dir = VECTOR ? !(y_in > 0) : (z_in >= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dir) begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				z_out <= z_in - ang;
			end else begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				z_out <= z_in + ang;
			end
			side_out <= side_in;
		end
	end

endmodule

`default_nettype wire

>>> src/lcsa_div_cell.sv
// ----------------------------------------------------------------------------
// lcsa_div_cell
// One quotient bit of the restoring divider, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_div_cell
	import lcsa_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vld_in,
	input  wire logic [63:0]       rem_in,
	input  wire logic [63:0]       den_in,
	input  wire logic [DIV_STEPS-1:0] q_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   vld_out,
	output logic [63:0]            rem_out,
	output logic [63:0]            den_out,
	output logic [DIV_STEPS-1:0]   q_out,
	output logic [SIDE_W-1:0]      side_out
);

	logic [63:0] twice;
	logic        ge;

	always_comb begin
		twice = {rem_in[62:0], 1'b0};
		ge    = twice >= den_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= ge ? twice - den_in : twice;
			q_out    <= {q_in[DIV_STEPS-2:0], ge};
			den_out  <= den_in;
			side_out <= side_in;
		end
	end

endmodule

`default_nettype wire

>>> src/lcsa_sqrt_cell.sv
// ----------------------------------------------------------------------------
// lcsa_sqrt_cell
// One digit of the bit-pair integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_sqrt_cell #(
	parameter int BITPOS = 62,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vld_in,
	input  wire logic [63:0]       v_in,
	input  wire logic [63:0]       res_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   vld_out,
	output logic [63:0]            v_out,
	output logic [63:0]            res_out,
	output logic [SIDE_W-1:0]      side_out
);

	localparam logic [63:0] BIT = 64'd1 << BITPOS;

	logic [63:0] trial;
	logic        ge;

	always_comb begin
		trial = res_in + BIT;
		ge    = v_in >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_out    <= ge ? v_in - trial : v_in;
			res_out  <= ge ? (res_in >> 1) + BIT : res_in >> 1;
			side_out <= side_in;
		end
	end

endmodule

`default_nettype wire

>>> src/lab_to_cm_scatter_angle.sv
// ----------------------------------------------------------------------------
// lab_to_cm_scatter_angle
// Two-body elastic scattering: lab polar angle to CM angle(s), fully pipelined.
// ----------------------------------------------------------------------------
// Usage
//  - Input channel (in_valid/in_ready): operation (0 heavy, 1 recoil) and
//    lab_angle in Q(ANGLE_FRAC_BITS) radians. One transaction per cycle while in_ready is high.
//  - Output channel (out_valid/out_ready): first_angle, second_angle and
//    domain_error, one transaction per input, in input order.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
//    always high; write only while the pipe is empty.
//  - Throughput: one transaction per cycle unless stalled; the chains are rows
//    of cells (rotation CORDIC, vectoring CORDIC, divider, square root, vectoring
//    CORDIC) with a register after each cell.
//  - Path: s1, rotation chain, s2, first vectoring chain, s3 to s5, divider,
//    s6, square root chain, second vectoring chain, output register.
//  - Stall: the whole row holds only when the last cell has a result and the
//    output register still holds one not taken; otherwise input keeps flowing.
//  - Reset: asynchronous, clears all valid flags and loads the register
//    defaults (gamma 1.0, beta 0, energies, momentum 0).
// ----------------------------------------------------------------------------
`default_nettype none

module lab_to_cm_scatter_angle
	import lcsa_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 29,
	parameter int CORDIC_STEPS    = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input transactions
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [29:0] lab_angle,
	// output transactions
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [32:0] first_angle,
	output logic signed [32:0] second_angle,
	output logic             domain_error,
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire cfg_idx_t    cfg_index,
	input  wire logic [31:0] cfg_data
);

	// angle format conversion shifts
	localparam int SH_IN_L = (ANGLE_FRAC_BITS <= 30) ? 30 - ANGLE_FRAC_BITS : 0;
	localparam int SH_IN_R = (ANGLE_FRAC_BITS > 30) ? ANGLE_FRAC_BITS - 30 : 0;
	localparam int SH_DN   = SH_IN_L;
	localparam int SH_UP   = SH_IN_R;
	localparam logic [63:0] RND = (64'd1 << SH_DN) >> 1;

	localparam int VSIDE_W = 65; // op, n1, u
	localparam int RSIDE_W = 33; // op, n1
	localparam int DSIDE_W = 34; // op, a, err, eq
	localparam int QSIDE_W = 64; // op, a, err, q
	localparam int WSIDE_W = 33; // op, a, err

	// ---------------------------------------------------------------- helpers
	function automatic logic [30:0] clamp_top(input cord_t v, input logic [31:0] hi);
		logic [30:0] r;
		if (v < 0)
			r = '0;
		else if (v > $signed({4'd0, hi}))
			r = hi[30:0];
		else
			r = v[30:0];
		return r;
	endfunction

	function automatic logic [32:0] to_out(input logic [63:0] v);
		logic [63:0] t;
		t = ((v + RND) >> SH_DN) << SH_UP;
		return t[32:0];
	endfunction

	// ------------------------------------------------------------- registers
	logic [31:0] gamma_q, beta_q, heavy_e_q, light_e_q, mom_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q   <= RST_GAMMA;
			beta_q    <= RST_BETA;
			heavy_e_q <= RST_HEAVY_E;
			light_e_q <= RST_LIGHT_E;
			mom_q     <= RST_MOM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAMMA:   gamma_q   <= cfg_data;
				REG_BETA:    beta_q    <= cfg_data;
				REG_HEAVY_E: heavy_e_q <= cfg_data;
				REG_LIGHT_E: light_e_q <= cfg_data;
				REG_MOM:     mom_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------- flow control
	logic en;
	logic last_vld;

	// hold only if the tail has a result and the output slot is still full
	assign en       = !(last_vld && out_valid && !out_ready);
	assign in_ready = en;

	// --------------------------------------------------------------- stages
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic        op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	logic [30:0] z_s1;
	logic [31:0] n1_s1, n1_s2;
	logic [30:0] c_s2;
	logic [31:0] u_s2;
	logic [30:0] a_s3, a_s4, a_s5, a_s6;
	logic [34:0] r_s3;
	logic [63:0] num_s3, num_s4, num_s5, den_s4, den_s5;
	logic        err_s5, eq_s5, err_s6;
	logic [30:0] q_s6;
	logic [63:0] v_s6;

	// stage 1 comb: format conversion, saturation to pi/2, beta*E
	logic [63:0] theta_w;
	logic [63:0] be_p;
	always_comb begin
		theta_w = ({34'd0, lab_angle} << SH_IN_L) >> SH_IN_R;
		be_p    = 64'(beta_q) * 64'(operation ? light_e_q : heavy_e_q);
	end

	// rotation chain
	logic               rv [0:CORDIC_STEPS];
	cord_t              rx [0:CORDIC_STEPS];
	cord_t              ry [0:CORDIC_STEPS];
	cord_t              rz [0:CORDIC_STEPS];
	logic [RSIDE_W-1:0] rs [0:CORDIC_STEPS];

	assign rv[0] = vld_s1;
	assign rx[0] = $signed({6'd0, INV_GAIN_Q30});
	assign ry[0] = '0;
	assign rz[0] = $signed({5'd0, z_s1});
	assign rs[0] = {op_s1, n1_s1};

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
		lcsa_cordic_cell #(.STEP(g), .VECTOR(1'b0), .SIDE_W(RSIDE_W)) u_cell (
			.clk, .arst_n, .en,
			.vld_in(rv[g]), .x_in(rx[g]), .y_in(ry[g]), .z_in(rz[g]), .side_in(rs[g]),
			.vld_out(rv[g+1]), .x_out(rx[g+1]), .y_out(ry[g+1]), .z_out(rz[g+1]),
			.side_out(rs[g+1])
		);
	end

	// stage 2 comb: clamp cos/sin, u = gamma*sin
	logic [30:0] c_cl, s_cl;
	logic [62:0] u_p;
	always_comb begin
		c_cl = clamp_top(rx[CORDIC_STEPS], ONE_Q30);
		s_cl = clamp_top(ry[CORDIC_STEPS], ONE_Q30);
		u_p  = 63'(gamma_q) * 63'(s_cl);
	end

	// first vectoring chain: atan(gamma*tan) and magnitude
	logic               vv [0:CORDIC_STEPS];
	cord_t              vx [0:CORDIC_STEPS];
	cord_t              vy [0:CORDIC_STEPS];
	cord_t              vz [0:CORDIC_STEPS];
	logic [VSIDE_W-1:0] vs [0:CORDIC_STEPS];

	assign vv[0] = vld_s2;
	assign vx[0] = $signed({5'd0, c_s2});
	assign vy[0] = $signed({4'd0, u_s2});
	assign vz[0] = '0;
	assign vs[0] = {op_s2, n1_s2, u_s2};

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec1
		lcsa_cordic_cell #(.STEP(g), .VECTOR(1'b1), .SIDE_W(VSIDE_W)) u_cell (
			.clk, .arst_n, .en,
			.vld_in(vv[g]), .x_in(vx[g]), .y_in(vy[g]), .z_in(vz[g]), .side_in(vs[g]),
			.vld_out(vv[g+1]), .x_out(vx[g+1]), .y_out(vy[g+1]), .z_out(vz[g+1]),
			.side_out(vs[g+1])
		);
	end

	// stage 3 comb: gain-corrected magnitude and numerator
	logic [34:0] mag_cl;
	logic [64:0] r_p;
	logic [63:0] num_p;
	logic [VSIDE_W-1:0] vtail;
	always_comb begin
		vtail  = vs[CORDIC_STEPS];
		mag_cl = vx[CORDIC_STEPS][CW-1] ? '0 : vx[CORDIC_STEPS][34:0];
		r_p    = 65'(mag_cl) * 65'(INV_GAIN_Q30);
		num_p  = 64'(vtail[63:32]) * 64'(vtail[31:2]);
	end

	// stage 4 comb: denominator
	logic [64:0] den_p;
	always_comb begin
		den_p = 65'(mom_q) * 65'(r_s3[34:2]);
	end

	// divider chain
	logic                 dv  [0:DIV_STEPS];
	logic [63:0]          drm [0:DIV_STEPS];
	logic [63:0]          ddn [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] dq  [0:DIV_STEPS];
	logic [DSIDE_W-1:0]   ds  [0:DIV_STEPS];

	assign dv[0]  = vld_s5;
	assign drm[0] = num_s5;
	assign ddn[0] = den_s5;
	assign dq[0]  = '0;
	assign ds[0]  = {op_s5, a_s5, err_s5, eq_s5};

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		lcsa_div_cell #(.SIDE_W(DSIDE_W)) u_cell (
			.clk, .arst_n, .en,
			.vld_in(dv[g]), .rem_in(drm[g]), .den_in(ddn[g]), .q_in(dq[g]),
			.side_in(ds[g]),
			.vld_out(dv[g+1]), .rem_out(drm[g+1]), .den_out(ddn[g+1]), .q_out(dq[g+1]),
			.side_out(ds[g+1])
		);
	end

	// stage 6 comb: q (exact one when equal), 1 - q^2
	logic [DSIDE_W-1:0] dtail;
	logic [30:0]        q_fin;
	logic [61:0]        q2_p;
	logic [30:0]        one_m;
	always_comb begin
		dtail = ds[DIV_STEPS];
		q_fin = dtail[0] ? ONE_Q30[30:0] : {1'b0, dq[DIV_STEPS]};
		q2_p  = 62'(q_fin) * 62'(q_fin);
		one_m = ONE_Q30[30:0] - q2_p[60:30];
	end

	// square root chain
	logic               qv [0:SQRT_STEPS];
	logic [63:0]        qvv[0:SQRT_STEPS];
	logic [63:0]        qr [0:SQRT_STEPS];
	logic [QSIDE_W-1:0] qs [0:SQRT_STEPS];

	assign qv[0]  = vld_s6;
	assign qvv[0] = v_s6;
	assign qr[0]  = '0;
	assign qs[0]  = {op_s6, a_s6, err_s6, q_s6};

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		lcsa_sqrt_cell #(.BITPOS(62 - 2 * g), .SIDE_W(QSIDE_W)) u_cell (
			.clk, .arst_n, .en,
			.vld_in(qv[g]), .v_in(qvv[g]), .res_in(qr[g]), .side_in(qs[g]),
			.vld_out(qv[g+1]), .v_out(qvv[g+1]), .res_out(qr[g+1]), .side_out(qs[g+1])
		);
	end

	// second vectoring chain: asin via atan2(q, root)
	logic               wv [0:CORDIC_STEPS];
	cord_t              wx [0:CORDIC_STEPS];
	cord_t              wy [0:CORDIC_STEPS];
	cord_t              wz [0:CORDIC_STEPS];
	logic [WSIDE_W-1:0] ws [0:CORDIC_STEPS];
	logic [QSIDE_W-1:0] qtail;

	assign qtail = qs[SQRT_STEPS];
	assign wv[0] = qv[SQRT_STEPS];
	assign wx[0] = $signed({5'd0, qr[SQRT_STEPS][30:0]});
	assign wy[0] = $signed({5'd0, qtail[30:0]});
	assign wz[0] = '0;
	assign ws[0] = qtail[63:31];

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec2
		lcsa_cordic_cell #(.STEP(g), .VECTOR(1'b1), .SIDE_W(WSIDE_W)) u_cell (
			.clk, .arst_n, .en,
			.vld_in(wv[g]), .x_in(wx[g]), .y_in(wy[g]), .z_in(wz[g]), .side_in(ws[g]),
			.vld_out(wv[g+1]), .x_out(wx[g+1]), .y_out(wy[g+1]), .z_out(wz[g+1]),
			.side_out(ws[g+1])
		);
	end

	// output comb: combine solutions, error forces zero angles
	logic [WSIDE_W-1:0] wtail;
	logic [30:0]        sa, a_fin;
	logic [63:0]        sum_as, first_w, second_w;
	logic               op_fin, err_fin;
	always_comb begin
		wtail    = ws[CORDIC_STEPS];
		op_fin   = wtail[32];
		a_fin    = wtail[31:1];
		err_fin  = wtail[0];
		sa       = clamp_top(wz[CORDIC_STEPS], HALF_PI_Q30);
		sum_as   = 64'(a_fin) + 64'(sa);
		first_w  = op_fin ? 64'(PI_Q30) - sum_as : sum_as;
		second_w = 64'(a_fin) + 64'(PI_Q30) - 64'(sa);
	end

	assign last_vld = wv[CORDIC_STEPS];

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en) begin
				vld_s1 <= in_valid;
				vld_s2 <= rv[CORDIC_STEPS];
				vld_s3 <= vv[CORDIC_STEPS];
				vld_s4 <= vld_s3;
				vld_s5 <= vld_s4;
				vld_s6 <= dv[DIV_STEPS];
			end
			if (en && last_vld)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= operation;
			z_s1   <= (theta_w > 64'(HALF_PI_Q30)) ? HALF_PI_Q30[30:0] : theta_w[30:0];
			n1_s1  <= be_p[63:32];

			op_s2  <= rs[CORDIC_STEPS][32];
			n1_s2  <= rs[CORDIC_STEPS][31:0];
			c_s2   <= c_cl;
			u_s2   <= u_p[61:30];

			op_s3  <= vtail[64];
			a_s3   <= clamp_top(vz[CORDIC_STEPS], HALF_PI_Q30);
			r_s3   <= r_p[64:30];
			num_s3 <= num_p;

			op_s4  <= op_s3;
			a_s4   <= a_s3;
			num_s4 <= num_s3;
			den_s4 <= den_p[63:0];

			op_s5  <= op_s4;
			a_s5   <= a_s4;
			num_s5 <= num_s4;
			den_s5 <= den_s4;
			err_s5 <= (den_s4 == '0) || (num_s4 > den_s4);
			eq_s5  <= num_s4 == den_s4;

			op_s6  <= dtail[33];
			a_s6   <= dtail[32:2];
			err_s6 <= dtail[1];
			q_s6   <= q_fin;
			v_s6   <= {3'd0, one_m, 30'd0};
		end
		if (en && last_vld) begin
			domain_error <= err_fin;
			first_angle  <= err_fin ? '0 : $signed(to_out(first_w));
			second_angle <= (err_fin || op_fin) ? '0 : $signed(to_out(second_w));
		end
	end

	// ------------------------------------------------------------ assertions
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && domain_error) |-> (first_angle == '0 && second_angle == '0))
		else $error("domain error with non-zero angles");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && last_vld))
		else $error("input held without a blocked output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(first_angle)
			&& $stable(second_angle) && $stable(domain_error)))
		else $error("pending output transaction changed");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s1)
		else $error("accepted input transaction lost at first stage");

endmodule

`default_nettype wire

>>> bench/lab_to_cm_scatter_angle_test.sv
// ----------------------------------------------------------------------------
// lab_to_cm_scatter_angle_test
// Self-checking bench for the lab-to-CM angle converter. A short table of
// directed angles runs first. Random angle streams follow, over several
// register settings. Each output is compared against a typed expectation
// or a bit-accurate model of the CORDIC, divider and square-root datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lab_to_cm_scatter_angle_test;
	import lcsa_pkg::*;

	localparam int  DRAIN_CYCLES = 200;
	localparam int  CYCLE_LIMIT  = 400000;
	localparam int  N_RND_PHASES = 6;
	localparam int  RND_PER_PHASE = 75;
	localparam logic OP_HEAVY  = 1'b0;
	localparam logic OP_RECOIL = 1'b1;
	localparam logic [29:0] ANG_MAX = 30'd843314856;   // pi/2 in Q1.29

	typedef struct packed {
		logic [32:0] first;
		logic [32:0] second;
		logic        dom_err;
	} cm_angles_t;

	typedef struct {
		logic        op;
		logic [29:0] ang;
		bit          typed;     // expectation typed in below
		cm_angles_t  res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = 1'b0;
	logic [29:0] lab_angle = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic signed [32:0] first_angle;
	logic signed [32:0] second_angle;
	logic        domain_error;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = REG_GAMMA;
	logic [31:0] cfg_data = '0;

	// local copy of the registers
	bit [63:0] m_gamma, m_beta, m_heavy_e, m_light_e, m_mom;

	cm_angles_t pending_angles[$];
	int  n_errors = 0;
	int  cycle_cnt = 0;
	bit  no_idle = 1'b0;        // phase runs both sides flat out
	int  rx_wait = 0;

	longint atan_q30[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149};

	lab_to_cm_scatter_angle u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.lab_angle   (lab_angle),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.first_angle (first_angle),
		.second_angle(second_angle),
		.domain_error(domain_error),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Datapath model
	// ------------------------------------------------------------------
	function automatic longint rot_angle(int i);
		if (i < 10)
			return atan_q30[i];
		if (i <= 30)
			return longint'(1) << (30 - i);
		return 0;
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// vectoring pass: returns the angle, magnitude through mag
	function automatic longint vec_angle(longint x, longint y, output longint mag);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += rot_angle(i);
			end else begin
				x -= dx; y += dy; z -= rot_angle(i);
			end
		end
		mag = x;
		return z;
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Q30 to Q29, round half up, 33-bit wrap
	function automatic logic [32:0] q30_to_out(longint v);
		bit [63:0] u;
		u = ($unsigned(64'(v)) + 64'd1) >> 1;
		return u[32:0];
	endfunction

	function automatic cm_angles_t predict_cm_angles(logic op, logic [29:0] ang);
		cm_angles_t r;
		longint theta, x, y, z, dx, dy, c, s, a, mag, sa, rmag;
		bit [63:0] u, rr, n1, num, den, q, q2, root, rem;
		theta = longint'(ang) << 1;
		if (theta > longint'(HALF_PI_Q30))
			theta = longint'(HALF_PI_Q30);
		x = longint'(INV_GAIN_Q30); y = 0; z = theta;
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= rot_angle(i);
			end else begin
				x += dx; y -= dy; z += rot_angle(i);
			end
		end
		c = clampl(x, 0, longint'(ONE_Q30));
		s = clampl(y, 0, longint'(ONE_Q30));
		u = (m_gamma * $unsigned(64'(s))) >> 30;
		a = clampl(vec_angle(c, longint'(u), mag), 0, longint'(HALF_PI_Q30));
		if (mag < 0)
			mag = 0;
		rr = ($unsigned(64'(mag)) * 64'(INV_GAIN_Q30)) >> 30;
		n1 = (m_beta * (op == OP_RECOIL ? m_light_e : m_heavy_e)) >> 32;
		num = n1 * (u >> 2);
		den = m_mom * (rr >> 2);
		r = '0;
		if (den == 0 || num > den) begin
			r.dom_err = 1'b1;
			return r;
		end
		if (num == den) begin
			q = 64'(ONE_Q30);
		end else begin
			rem = num;
			q = 0;
			for (int k = 0; k < 30; k++) begin
				q <<= 1;
				if (rem >= den - rem) begin
					rem = rem - (den - rem);
					q |= 1;
				end else begin
					rem <<= 1;
				end
			end
		end
		q2 = (q * q) >> 30;
		root = int_sqrt((64'(ONE_Q30) - q2) << 30);
		sa = clampl(vec_angle(longint'(root), longint'(q), rmag), 0, longint'(HALF_PI_Q30));
		if (op == OP_RECOIL) begin
			r.first = q30_to_out(longint'(PI_Q30) - (a + sa));
		end else begin
			r.first  = q30_to_out(a + sa);
			r.second = q30_to_out(a + longint'(PI_Q30) - sa);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [32:0] got, logic [32:0] want);
		$display("mismatch %s: got %0h, expected %0h", what, got, want);
		n_errors++;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_GAMMA:   m_gamma   = val;
			REG_BETA:    m_beta    = val;
			REG_HEAVY_E: m_heavy_e = val;
			REG_LIGHT_E: m_light_e = val;
			REG_MOM:     m_mom     = val;
			default: ;
		endcase
	endtask

	task automatic load_settings(logic [31:0] g, logic [31:0] b, logic [31:0] he,
			logic [31:0] le, logic [31:0] p);
		write_reg(REG_GAMMA, g);
		write_reg(REG_BETA, b);
		write_reg(REG_HEAVY_E, he);
		write_reg(REG_LIGHT_E, le);
		write_reg(REG_MOM, p);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// pipe fully empty; only then may registers change
	task automatic drain_pipe();
		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_angle(logic op, logic [29:0] ang, bit typed, cm_angles_t res);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		lab_angle <= ang;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_angles.push_back(typed ? res : predict_cm_angles(op, ang));
	endtask

	function automatic logic [29:0] rand_angle();
		if ($urandom_range(0, 9) < 8)
			return 30'($urandom_range(0, ANG_MAX));
		return 30'($urandom);
	endfunction

	// sets the momentum so that the asin argument lands around one
	task automatic load_random_settings();
		logic [31:0] g, b, he, le;
		bit [63:0] n1, p;
		g  = $urandom_range(0, 3) == 0 ? $urandom_range(32'h4000_0000, 32'hFFFF_FFFF)
			: $urandom_range(32'h4000_0000, 32'h6000_0000);
		b  = $urandom_range(0, 32'hC000_0000);
		he = $urandom_range(32'h0010_0000, 32'h1000_0000);
		le = $urandom_range(32'h0010_0000, 32'h1000_0000);
		n1 = (64'(b) * 64'(he > le ? he : le)) >> 32;
		p  = n1 * $urandom_range(4, 24) / 8;
		if (p == 0)
			p = 1;
		if (p > 64'hFFFF_FFFF)
			p = 64'hFFFF_FFFF;
		load_settings(g, b, he, le, p[31:0]);
	endtask

	// ------------------------------------------------------------------
	// Output side: random stalls, then compare against the oldest entry
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cm_angles_t want;
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_angles.size() == 0) begin
					report_mismatch("unexpected transaction", first_angle, '0);
				end else begin
					want = pending_angles.pop_front();
					if (first_angle !== want.first)
						report_mismatch("first_angle", first_angle, want.first);
					if (second_angle !== want.second)
						report_mismatch("second_angle", second_angle, want.second);
					if (domain_error !== want.dom_err)
						report_mismatch("domain_error", 33'(domain_error), 33'(want.dom_err));
				end
				rx_wait = no_idle ? 0 : $urandom_range(0, 8);
				out_ready <= (rx_wait == 0);
			end else if (!out_ready) begin
				if (rx_wait > 0)
					rx_wait--;
				out_ready <= (rx_wait == 0);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	localparam int N_RESET_ROWS = 4;
	stim_row_t dir_rows[] = '{
		// reset settings: momentum zero, so every angle is a domain error
		'{OP_HEAVY,  30'd0,           1'b1, '{33'd0, 33'd0, 1'b1}},
		'{OP_RECOIL, ANG_MAX,         1'b1, '{33'd0, 33'd0, 1'b1}},
		'{OP_HEAVY,  30'h3FFF_FFFF,   1'b1, '{33'd0, 33'd0, 1'b1}},
		'{OP_RECOIL, 30'd421657428,   1'b1, '{33'd0, 33'd0, 1'b1}},
		// moderate boost: both particles, zero, pi/2, saturation
		'{OP_HEAVY,  30'd0,           1'b0, '{default: '0}},
		'{OP_RECOIL, 30'd0,           1'b0, '{default: '0}},
		'{OP_HEAVY,  30'd1,           1'b0, '{default: '0}},
		'{OP_HEAVY,  ANG_MAX,         1'b0, '{default: '0}},
		'{OP_RECOIL, ANG_MAX,         1'b0, '{default: '0}},
		'{OP_HEAVY,  30'd843314857,   1'b0, '{default: '0}},
		'{OP_RECOIL, 30'h3FFF_FFFF,   1'b0, '{default: '0}},
		'{OP_HEAVY,  30'h2AAA_AAAA,   1'b0, '{default: '0}},
		'{OP_HEAVY,  30'd281104952,   1'b0, '{default: '0}},
		'{OP_RECOIL, 30'd562209904,   1'b0, '{default: '0}},
		'{OP_HEAVY,  30'd700000000,   1'b0, '{default: '0}},
		'{OP_RECOIL, 30'd100000,      1'b0, '{default: '0}}
	};

	initial begin
		m_gamma = RST_GAMMA; m_beta = RST_BETA; m_heavy_e = RST_HEAVY_E;
		m_light_e = RST_LIGHT_E; m_mom = RST_MOM;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		out_ready <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (i == N_RESET_ROWS) begin
				in_valid <= 1'b0;
				drain_pipe();
				// gamma 1.2, beta 0.3, momentum 1200 MeV/c
				load_settings(32'd1288490189, 32'd1288490189, RST_HEAVY_E, RST_LIGHT_E,
					32'd78643200);
			end
			send_angle(dir_rows[i].op, dir_rows[i].ang, dir_rows[i].typed, dir_rows[i].res);
		end

		// extremes of every register, then random settings
		for (int ph = 0; ph < N_RND_PHASES + 2; ph++) begin
			in_valid <= 1'b0;
			drain_pipe();
			if (ph == 0)
				load_settings('1, '1, '1, '1, '1);
			else if (ph == 1)
				load_settings(32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'd1);
			else
				load_random_settings();
			no_idle = (ph == 3);
			for (int n = 0; n < (ph < 2 ? 20 : RND_PER_PHASE); n++) begin
				if (ph == 4 && n == 40) begin
					// hold off until every result is home
					in_valid <= 1'b0;
					while (pending_angles.size() != 0)
						@(posedge clk);
				end
				send_angle($urandom_range(0, 1), rand_angle(), 1'b0, '{default: '0});
			end
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;
		drain_pipe();

		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

>>> lab_to_cm_scatter_angle.f
src/lcsa_pkg.sv
src/lcsa_cordic_cell.sv
src/lcsa_div_cell.sv
src/lcsa_sqrt_cell.sv
src/lab_to_cm_scatter_angle.sv
bench/lab_to_cm_scatter_angle_test.sv
